@@ hw/rtl/swar_pkg.sv @@
// ----------------------------------------------------------------------------
// swar_pkg
// Shared types and constants for the sliding window arrival ratio block.
// ----------------------------------------------------------------------------
package swar_pkg;

    localparam int CNT_W     = 11;
    localparam int PCT_W     = 15;
    localparam int PROD_W    = 26;
    localparam int SCALE_PCT = 25600;

    typedef enum logic {
        REQ_RECORD = 1'b0,
        REQ_QUERY  = 1'b1
    } t_req;

    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [PCT_W-1:0] t_pct;

    typedef struct packed {
        logic start;
        t_cnt num;
        t_cnt den;
    } t_div_req;

    typedef struct packed {
        logic done;
        t_pct quot;
    } t_div_rsp;

endpackage

@@ hw/rtl/swar_hist_mem.sv @@
// ----------------------------------------------------------------------------
// swar_hist_mem
// Arrival flag history: one write port, one registered read port.
// ----------------------------------------------------------------------------
module swar_hist_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);

    logic r_mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/swar_div.sv @@
// ----------------------------------------------------------------------------
// swar_div
// Percentage unit: scales the count by 25600 and divides by the window,
// one restoring quotient bit per cycle.
// ----------------------------------------------------------------------------
module swar_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swar_pkg::t_div_req i_req,
    output swar_pkg::t_div_rsp o_rsp
);

    import swar_pkg::*;

    localparam int STEP_W = $clog2(PCT_W + 1);

    logic [CNT_W-1:0]  r_rem;
    logic [PCT_W-1:0]  r_low;
    logic [PCT_W-1:0]  r_quot;
    logic [CNT_W-1:0]  r_den;
    logic [STEP_W-1:0] r_steps;
    logic              r_busy;
    logic              r_done;

    logic [PROD_W-1:0] prod;
    logic [CNT_W:0]    trial;
    logic              fits;

    assign prod  = PROD_W'(i_req.num) * PROD_W'(SCALE_PCT);
    assign trial = {r_rem, r_low[PCT_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_steps <= STEP_W'(PCT_W);
                r_rem   <= prod[PROD_W-1:PCT_W];
                r_low   <= prod[PCT_W-1:0];
                r_den   <= i_req.den;
                r_quot  <= '0;
            end else if (r_busy) begin
                r_rem   <= fits ? CNT_W'(trial - {1'b0, r_den}) : trial[CNT_W-1:0];
                r_low   <= {r_low[PCT_W-2:0], 1'b0};
                r_quot  <= {r_quot[PCT_W-2:0], fits};
                r_steps <= r_steps - 1'b1;
                if (r_steps == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

@@ hw/rtl/sliding_window_arrival_ratio.sv @@
// ----------------------------------------------------------------------------
// sliding_window_arrival_ratio
// Ring of recent arrival flags; a query counts arrivals over the newest
// window and returns the count, the window and the percentage in Q8.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------------
//  in      | i_in_valid / o_in_stall | i_req_type, i_arrived, i_window_request
//  out     | o_out_valid/ i_out_stall| o_received_count, o_window_used, o_percent_q8
//
//  A query walks a window of W flags, one history read per cycle, then runs
//  the divider; an empty window skips both. Reset is synchronous and empties
//  the ring. A stalled result holds in the output register; records and new
//  queries are taken meanwhile, and a query waits only to hand over its own
//  result.
// ----------------------------------------------------------------------------
module sliding_window_arrival_ratio #(
    parameter int HISTORY_BITS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_req_type,
    input  logic                  i_arrived,
    input  logic [10:0]           i_window_request,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [10:0]           o_received_count,
    output logic [10:0]           o_window_used,
    output swar_pkg::t_pct        o_percent_q8
);

    import swar_pkg::*;

    localparam int PW = $clog2(HISTORY_BITS);
    localparam int FW = $clog2(HISTORY_BITS + 1);
    localparam int CW = (FW > CNT_W) ? FW : CNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DIV,
        S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic [PW-1:0] r_newest, n_newest;
    logic [FW-1:0] r_fill, n_fill;
    logic [PW-1:0] r_rd_pos, n_rd_pos;
    t_cnt          r_left, n_left;
    logic          r_rd_vld, n_rd_vld;
    t_cnt          r_got, n_got;
    t_cnt          r_used, n_used;
    t_pct          r_pct, n_pct;
    logic          r_div_start, n_div_start;
    logic          r_out_valid, n_out_valid;
    t_cnt          r_o_got, n_o_got;
    t_cnt          r_o_used, n_o_used;
    t_pct          r_o_pct, n_o_pct;

    logic          accept;
    logic          mem_we;
    logic          rdata;
    logic [PW-1:0] next_pos;
    logic [CW-1:0] req_ext;
    logic [CW-1:0] fill_ext;
    logic [CW-1:0] used_ext;
    t_div_req      div_req;
    t_div_rsp      div_rsp;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign next_pos   = (r_newest == PW'(HISTORY_BITS - 1)) ? '0 : r_newest + 1'b1;
    assign mem_we     = accept && (t_req'(i_req_type) == REQ_RECORD);
    assign req_ext    = CW'(i_window_request);
    assign fill_ext   = CW'(r_fill);
    assign used_ext   = (req_ext < fill_ext) ? req_ext : fill_ext;

    assign div_req.start = r_div_start;
    assign div_req.num   = r_got;
    assign div_req.den   = r_used;

    swar_hist_mem #(
        .DEPTH (HISTORY_BITS),
        .AW    (PW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (next_pos),
        .i_wdata (i_arrived),
        .i_raddr (r_rd_pos),
        .o_rdata (rdata)
    );

    swar_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_newest    = r_newest;
        n_fill      = r_fill;
        n_rd_pos    = r_rd_pos;
        n_left      = r_left;
        n_rd_vld    = 1'b0;
        n_got       = r_got;
        n_used      = r_used;
        n_pct       = r_pct;
        n_div_start = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_got     = r_o_got;
        n_o_used    = r_o_used;
        n_o_pct     = r_o_pct;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (t_req'(i_req_type) == REQ_RECORD) begin
                        n_newest = next_pos;
                        if (r_fill != FW'(HISTORY_BITS)) begin
                            n_fill = r_fill + 1'b1;
                        end
                    end else begin
                        n_used   = used_ext[CNT_W-1:0];
                        n_left   = used_ext[CNT_W-1:0];
                        n_rd_pos = r_newest;
                        n_got    = '0;
                        n_pct    = '0;
                        n_state  = (used_ext == '0) ? S_DONE : S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (r_left != '0) begin
                    n_rd_pos = (r_rd_pos == '0) ? PW'(HISTORY_BITS - 1) : r_rd_pos - 1'b1;
                    n_left   = r_left - 1'b1;
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld) begin
                    n_got = r_got + CNT_W'(rdata);
                end
                if ((r_left == '0) && !r_rd_vld) begin
                    n_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_pct   = div_rsp.quot;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_got     = r_got;
                    n_o_used    = r_used;
                    n_o_pct     = r_pct;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_newest    <= PW'(HISTORY_BITS - 1);
            r_fill      <= '0;
            r_rd_vld    <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_newest    <= n_newest;
            r_fill      <= n_fill;
            r_rd_vld    <= n_rd_vld;
            r_div_start <= n_div_start;
            r_out_valid <= n_out_valid;
        end
        r_rd_pos <= n_rd_pos;
        r_left   <= n_left;
        r_got    <= n_got;
        r_used   <= n_used;
        r_pct    <= n_pct;
        r_o_got  <= n_o_got;
        r_o_used <= n_o_used;
        r_o_pct  <= n_o_pct;
    end

    assign o_out_valid      = r_out_valid;
    assign o_received_count = r_o_got;
    assign o_window_used    = r_o_used;
    assign o_percent_q8     = r_o_pct;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks sliding_window_arrival_ratio against an in-bench copy of the arrival
// ring. Each accepted record updates the copy. Each accepted query queues the
// count, window and Q8 percentage worked out from it, and every result
// transaction is compared with the oldest queued entry. Stimulus covers an
// empty ring, clamped and oversized windows, random traffic while the ring
// fills, a long output hold that backs up the input, and late traffic with
// all-arrived and all-lost runs.
// ----------------------------------------------------------------------------
module testbench;
    import swar_pkg::*;

    localparam int DEPTH         = 1024;
    localparam int MAX_WIN       = 1024;
    localparam int SETTLE_CYCLES = 1100;

    typedef struct packed {
        t_cnt count;
        t_cnt window;
        t_pct pct;
    } t_ratio;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_req_type;
    logic        i_arrived;
    logic [10:0] i_window_request;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [10:0] o_received_count;
    logic [10:0] o_window_used;
    t_pct        o_percent_q8;

    bit     ring_flags [DEPTH];
    int     ring_newest = DEPTH - 1;
    int     ring_fill = 0;
    t_ratio pending_ratios [$];

    int errors = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;
    int max_gap = 6;
    int hold_request = 0;
    int loss_pct = 50;
    int loss_levels [5] = '{0, 5, 50, 95, 100};

    sliding_window_arrival_ratio dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("sliding_window_arrival_ratio: mismatch");
        $finish;
    end

    function automatic void store_flag(input logic arrived);
        ring_newest = (ring_newest + 1) % DEPTH;
        ring_flags[ring_newest] = arrived;
        if (ring_fill < DEPTH) begin
            ring_fill++;
        end
    endfunction

    function automatic t_ratio predict_ratio(input int window);
        t_ratio r;
        int used;
        int got;
        int pos;
        used = (window > ring_fill) ? ring_fill : window;
        got = 0;
        pos = ring_newest;
        for (int k = 0; k < used; k++) begin
            got += ring_flags[pos];
            pos = (pos == 0) ? DEPTH - 1 : pos - 1;
        end
        r.count = t_cnt'(got);
        r.window = t_cnt'(used);
        r.pct = (used == 0) ? '0 : t_pct'((got * SCALE_PCT) / used);
        return r;
    endfunction

    task automatic send_item(input t_req req, input logic arrived, input int window);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, max_gap);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_arrived <= arrived;
        i_window_request <= window[10:0];
        do @(posedge i_clk); while (o_in_stall);
        if (req == REQ_RECORD) begin
            store_flag(arrived);
        end else begin
            pending_ratios.push_back(predict_ratio(window));
        end
    endtask

    task automatic send_record();
        send_item(REQ_RECORD, $urandom_range(0, 99) >= loss_pct, $urandom_range(0, MAX_WIN));
    endtask

    task automatic send_query(input int window);
        send_item(REQ_QUERY, $urandom_range(0, 1), window);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_ratios.size() != 0);
    endtask

    task automatic test_empty_ring();
        send_query(0);
        send_query(MAX_WIN);
        send_query(1);
    endtask

    task automatic test_first_flags();
        send_item(REQ_RECORD, 1'b1, MAX_WIN);
        send_query(1);
        send_item(REQ_RECORD, 1'b0, 2047 & MAX_WIN);
        send_query(2);
        send_query(0);
        send_item(REQ_RECORD, 1'b0, 0);
        send_query(3);
        send_query(MAX_WIN);
        send_query(MAX_WIN - 1);
        send_query(4);
        send_item(REQ_RECORD, 1'b1, 1);
        send_item(REQ_RECORD, 1'b1, 1023);
        send_query(5);
    endtask

    task automatic test_random_traffic(input int n_items);
        int win;
        for (int k = 0; k < n_items; k++) begin
            if (k % 40 == 0) begin
                loss_pct = loss_levels[$urandom_range(0, 4)];
            end
            if (k % 100 == 0) begin
                gaps_on = ($urandom_range(0, 2) != 0);
            end
            if (k % 150 == 149) begin
                drain_results();
            end
            if ($urandom_range(0, 99) < 55) begin
                send_record();
            end else begin
                case ($urandom_range(0, 9))
                    0: win = 0;
                    1: win = MAX_WIN;
                    2: win = ring_fill;
                    3: win = (ring_fill < MAX_WIN) ? ring_fill + 1 : MAX_WIN;
                    4, 5: win = $urandom_range(0, MAX_WIN);
                    default: win = $urandom_range(0, 32);
                endcase
                send_query(win);
            end
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_output_hold();
        drain_results();
        hold_request = 400;
        loss_pct = 50;
        send_query(8);
        send_query(16);
        for (int k = 0; k < 30; k++) begin
            if (k % 3 == 0) begin
                send_query($urandom_range(0, 40));
            end else begin
                send_record();
            end
        end
        drain_results();
    endtask

    task automatic test_late_traffic();
        for (int k = 0; k < 100; k++) begin
            if (k % 25 == 0) begin
                loss_pct = loss_levels[$urandom_range(0, 4)];
            end
            send_record();
            if (k % 50 == 49) begin
                send_query(MAX_WIN);
            end else if (k % 25 == 24) begin
                send_query($urandom_range(1, 64));
            end
        end
        send_query(MAX_WIN - 1);
        send_query(1);
        send_query($urandom_range(0, MAX_WIN));
        loss_pct = 0;
        repeat (20) send_record();
        send_query(20);
        loss_pct = 100;
        repeat (10) send_record();
        send_query(MAX_WIN);
        send_query(10);
        send_query(11);
    endtask

    initial begin
        int hold_left;
        int cyc;
        hold_left = 0;
        cyc = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case ((cyc / 256) % 4)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= ((cyc % 7) < 3);
                endcase
            end
        end
    end

    initial begin
        t_ratio want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (pending_ratios.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result count %0d window %0d percent %0d",
                             $time, o_received_count, o_window_used, o_percent_q8);
                end else begin
                    want = pending_ratios.pop_front();
                    if (o_received_count !== want.count || o_window_used !== want.window ||
                        o_percent_q8 !== want.pct) begin
                        errors++;
                        $display("%0t: expected count %0d window %0d percent %0d, got %0d %0d %0d",
                                 $time, want.count, want.window, want.pct,
                                 o_received_count, o_window_used, o_percent_q8);
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_req_type <= REQ_RECORD;
        i_arrived <= 1'b0;
        i_window_request <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_ring();
        test_first_flags();
        test_random_traffic(360);
        test_output_hold();
        test_late_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("sliding_window_arrival_ratio: match");
        end else begin
            $display("sliding_window_arrival_ratio: mismatch");
        end
        $finish;
    end

endmodule
